/* src/wiaf_pkg.sv */
// ----------------------------------------------------------------------------
// wiaf_pkg
// shared action codes, compare outcomes and the control word that travels
// down the pipeline next to each item
// ----------------------------------------------------------------------------
package wiaf_pkg;

  localparam int FIELD_BITS = 64;

  localparam logic [3:0] ACT_ADD  = 4'd0;
  localparam logic [3:0] ACT_SUB  = 4'd1;
  localparam logic [3:0] ACT_NEG  = 4'd2;
  localparam logic [3:0] ACT_NOT  = 4'd3;
  localparam logic [3:0] ACT_AND  = 4'd4;
  localparam logic [3:0] ACT_OR   = 4'd5;
  localparam logic [3:0] ACT_XOR  = 4'd6;
  localparam logic [3:0] ACT_CMP  = 4'd7;
  localparam logic [3:0] ACT_UMUL = 4'd8;
  localparam logic [3:0] ACT_SMUL = 4'd9;

  localparam logic [1:0] CMP_LESS    = 2'd0;
  localparam logic [1:0] CMP_EQUAL   = 2'd1;
  localparam logic [1:0] CMP_GREATER = 2'd2;

  typedef struct packed {
    logic       valid;
    logic       mul;
    logic       neg;
    logic       carry;
    logic       overflow;
    logic [1:0] cmp;
  } ctrl_t;

endpackage

/* src/wide_integer_alu_with_flags_unit.sv */
// ----------------------------------------------------------------------------
// wide_integer_alu_with_flags_unit
// two's complement alu with carry, overflow and compare outcome
// ----------------------------------------------------------------------------
// the result strobe follows each item through the front, partial product, row sum, final sum and output registers
// throughput: one item per cycle, every one of the five stages takes a new item each cycle
// busy stays low; the receiver cannot stall, so every item flows straight through
// reset clears all valid bits; items in flight are dropped
// ----------------------------------------------------------------------------
module wide_integer_alu_with_flags_unit #(
  parameter int VALUE_BITS = 64,
  parameter int PART_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [3:0]                      action,
  input  logic [wiaf_pkg::FIELD_BITS-1:0] operand_a,
  input  logic [wiaf_pkg::FIELD_BITS-1:0] operand_b,
  input  logic                            signed_compare,
  output logic                            done,
  output logic [wiaf_pkg::FIELD_BITS-1:0] result_value,
  output logic                            carry_flag,
  output logic                            overflow_flag,
  output logic [1:0]                      compare_outcome
);

  localparam int VB = VALUE_BITS;
  localparam int NL = (VALUE_BITS + PART_BITS - 1) / PART_BITS;
  localparam int PW = 2 * NL * PART_BITS;

  wiaf_pkg::ctrl_t f_ctrl;
  logic [VB-1:0]   f_value;
  logic [VB-1:0]   f_mag_a;
  logic [VB-1:0]   f_mag_b;
  wiaf_pkg::ctrl_t m_ctrl;
  logic [VB-1:0]   m_value;
  logic [PW-1:0]   m_product;
  logic [VB-1:0]   prod_lo;
  logic [VB-1:0]   prod_signed;
  logic            prod_big;

  assign busy = 1'b0;

  wiaf_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (start && !busy),
    .action         (action),
    .operand_a      (operand_a),
    .operand_b      (operand_b),
    .signed_compare (signed_compare),
    .ctrl           (f_ctrl),
    .value          (f_value),
    .mag_a          (f_mag_a),
    .mag_b          (f_mag_b)
  );

  wiaf_mul #(
    .VALUE_BITS (VALUE_BITS),
    .PART_BITS  (PART_BITS)
  ) u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_ctrl   (f_ctrl),
    .in_value  (f_value),
    .mag_a     (f_mag_a),
    .mag_b     (f_mag_b),
    .out_ctrl  (m_ctrl),
    .out_value (m_value),
    .product   (m_product)
  );

  assign prod_lo     = m_product[VB-1:0];
  assign prod_signed = m_ctrl.neg ? ('0 - prod_lo) : prod_lo;
  // any magnitude bit above the kept half flags the multiply
  assign prod_big    = |m_product[PW-1:VB];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ctrl.mul) begin
      result_value  <= wiaf_pkg::FIELD_BITS'(prod_signed);
      carry_flag    <= prod_big;
      overflow_flag <= prod_big;
    end else begin
      result_value  <= wiaf_pkg::FIELD_BITS'(m_value);
      carry_flag    <= m_ctrl.carry;
      overflow_flag <= m_ctrl.overflow;
    end
    compare_outcome <= m_ctrl.cmp;
  end

endmodule

/* src/wiaf_front.sv */
// ----------------------------------------------------------------------------
// wiaf_front
// first stage: add, sub, negate, logic and compare results with flags, and
// the operand magnitudes for the multiplier
// ----------------------------------------------------------------------------
module wiaf_front #(
  parameter int VALUE_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  logic [3:0]                        action,
  input  logic [wiaf_pkg::FIELD_BITS-1:0]   operand_a,
  input  logic [wiaf_pkg::FIELD_BITS-1:0]   operand_b,
  input  logic                              signed_compare,
  output wiaf_pkg::ctrl_t                   ctrl,
  output logic [VALUE_BITS-1:0]             value,
  output logic [VALUE_BITS-1:0]             mag_a,
  output logic [VALUE_BITS-1:0]             mag_b
);

  localparam int VB = VALUE_BITS;

  logic [VB-1:0]   a;
  logic [VB-1:0]   b;
  logic [VB:0]     add_sum;
  logic [VB:0]     sub_diff;
  logic [VB-1:0]   neg_a;
  logic [VB-1:0]   neg_b;
  wiaf_pkg::ctrl_t ctrl_next;
  logic [VB-1:0]   value_next;
  logic [VB-1:0]   mag_a_next;
  logic [VB-1:0]   mag_b_next;

  assign a        = operand_a[VB-1:0];
  assign b        = operand_b[VB-1:0];
  assign add_sum  = {1'b0, a} + {1'b0, b};
  assign sub_diff = {1'b0, a} - {1'b0, b};
  assign neg_a    = '0 - a;
  assign neg_b    = '0 - b;

  always_comb begin
    ctrl_next          = '0;
    ctrl_next.valid    = take;
    ctrl_next.cmp      = wiaf_pkg::CMP_EQUAL;
    value_next         = '0;
    mag_a_next         = a;
    mag_b_next         = b;
    case (action)
      wiaf_pkg::ACT_ADD: begin
        value_next         = add_sum[VB-1:0];
        ctrl_next.carry    = add_sum[VB];
        ctrl_next.overflow = (a[VB-1] ^ add_sum[VB-1]) & (b[VB-1] ^ add_sum[VB-1]);
      end
      wiaf_pkg::ACT_SUB: begin
        value_next         = sub_diff[VB-1:0];
        ctrl_next.carry    = sub_diff[VB];
        ctrl_next.overflow = (a[VB-1] ^ b[VB-1]) & (a[VB-1] ^ sub_diff[VB-1]);
      end
      wiaf_pkg::ACT_NEG: begin
        // only the most negative value stays negative after negation
        value_next         = neg_a;
        ctrl_next.carry    = |a;
        ctrl_next.overflow = a[VB-1] & neg_a[VB-1];
      end
      wiaf_pkg::ACT_NOT: begin
        value_next = ~a;
      end
      wiaf_pkg::ACT_AND: begin
        value_next = a & b;
      end
      wiaf_pkg::ACT_OR: begin
        value_next = a | b;
      end
      wiaf_pkg::ACT_XOR: begin
        value_next = a ^ b;
      end
      wiaf_pkg::ACT_CMP: begin
        if (signed_compare && (a[VB-1] != b[VB-1])) begin
          ctrl_next.cmp = a[VB-1] ? wiaf_pkg::CMP_LESS : wiaf_pkg::CMP_GREATER;
        end else if (sub_diff[VB]) begin
          ctrl_next.cmp = wiaf_pkg::CMP_LESS;
        end else if (a == b) begin
          ctrl_next.cmp = wiaf_pkg::CMP_EQUAL;
        end else begin
          ctrl_next.cmp = wiaf_pkg::CMP_GREATER;
        end
      end
      wiaf_pkg::ACT_UMUL: begin
        ctrl_next.mul = 1'b1;
      end
      wiaf_pkg::ACT_SMUL: begin
        ctrl_next.mul = 1'b1;
        ctrl_next.neg = a[VB-1] ^ b[VB-1];
        mag_a_next    = a[VB-1] ? neg_a : a;
        mag_b_next    = b[VB-1] ? neg_b : b;
      end
      default: begin
        ctrl_next.cmp = wiaf_pkg::CMP_EQUAL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else begin
      ctrl.valid <= ctrl_next.valid;
    end
    ctrl.mul      <= ctrl_next.mul;
    ctrl.neg      <= ctrl_next.neg;
    ctrl.carry    <= ctrl_next.carry;
    ctrl.overflow <= ctrl_next.overflow;
    ctrl.cmp      <= ctrl_next.cmp;
    value         <= value_next;
    mag_a         <= mag_a_next;
    mag_b         <= mag_b_next;
  end

endmodule

/* src/wiaf_mul.sv */
// ----------------------------------------------------------------------------
// wiaf_mul
// three-stage limb multiplier: partial products, row sums, final sum;
// carries each item's control word and simple result alongside
// ----------------------------------------------------------------------------
module wiaf_mul #(
  parameter int VALUE_BITS = 64,
  parameter int PART_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  wiaf_pkg::ctrl_t                        in_ctrl,
  input  logic [VALUE_BITS-1:0]                  in_value,
  input  logic [VALUE_BITS-1:0]                  mag_a,
  input  logic [VALUE_BITS-1:0]                  mag_b,
  output wiaf_pkg::ctrl_t                        out_ctrl,
  output logic [VALUE_BITS-1:0]                  out_value,
  output logic [2*((VALUE_BITS+PART_BITS-1)/PART_BITS)*PART_BITS-1:0] product
);

  localparam int PB = PART_BITS;
  localparam int NL = (VALUE_BITS + PART_BITS - 1) / PART_BITS;
  localparam int EW = NL * PART_BITS;
  localparam int PW = 2 * EW;

  logic [EW-1:0]   ext_a;
  logic [EW-1:0]   ext_b;
  logic [2*PB-1:0] pp [NL][NL];
  logic [PW-1:0]   row_next [NL];
  logic [PW-1:0]   row [NL];
  logic [PW-1:0]   product_next;

  wiaf_pkg::ctrl_t       ctrl_pp;
  wiaf_pkg::ctrl_t       ctrl_row;
  logic [VALUE_BITS-1:0] value_pp;
  logic [VALUE_BITS-1:0] value_row;

  assign ext_a = EW'(mag_a);
  assign ext_b = EW'(mag_b);

  // one limb by limb product per lane
  always_ff @(posedge clk) begin
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        pp[i][j] <= ext_a[i*PB +: PB] * ext_b[j*PB +: PB];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NL; j++) begin
        row_next[i] = row_next[i] + (PW'(pp[i][j]) << (j * PB));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NL; i++) begin
      row[i] <= row_next[i];
    end
  end

  always_comb begin
    product_next = '0;
    for (int i = 0; i < NL; i++) begin
      product_next = product_next + (row[i] << (i * PB));
    end
  end

  always_ff @(posedge clk) begin
    product <= product_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_pp.valid  <= 1'b0;
      ctrl_row.valid <= 1'b0;
      out_ctrl.valid <= 1'b0;
    end else begin
      ctrl_pp.valid  <= in_ctrl.valid;
      ctrl_row.valid <= ctrl_pp.valid;
      out_ctrl.valid <= ctrl_row.valid;
    end
    ctrl_pp.mul       <= in_ctrl.mul;
    ctrl_pp.neg       <= in_ctrl.neg;
    ctrl_pp.carry     <= in_ctrl.carry;
    ctrl_pp.overflow  <= in_ctrl.overflow;
    ctrl_pp.cmp       <= in_ctrl.cmp;
    ctrl_row.mul      <= ctrl_pp.mul;
    ctrl_row.neg      <= ctrl_pp.neg;
    ctrl_row.carry    <= ctrl_pp.carry;
    ctrl_row.overflow <= ctrl_pp.overflow;
    ctrl_row.cmp      <= ctrl_pp.cmp;
    out_ctrl.mul      <= ctrl_row.mul;
    out_ctrl.neg      <= ctrl_row.neg;
    out_ctrl.carry    <= ctrl_row.carry;
    out_ctrl.overflow <= ctrl_row.overflow;
    out_ctrl.cmp      <= ctrl_row.cmp;
    value_pp          <= in_value;
    value_row         <= value_pp;
    out_value         <= value_row;
  end

endmodule
